/* hw/rtl/nrd_pkg.sv */
// ----------------------------------------------------------------------------
// nrd_pkg
// Shared types, constants and helpers for the nearest direction gradient block.
// ----------------------------------------------------------------------------
package nrd_pkg;

  localparam int MAX_REFS   = 16;
  localparam int SLOT_W     = $clog2(MAX_REFS);
  localparam int CNT_W      = 5;
  localparam int THR_W      = 15;
  localparam int VEC_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_REF_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_THR = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BELOW = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;

  localparam logic [THR_W-1:0]  ANGLE_PI      = 15'd25736;
  localparam logic [THR_W-1:0]  ANGLE_HALF_PI = 15'd12868;
  localparam logic signed [19:0] HALF_PI_Q16  = 20'sd102944;

  typedef struct packed {
    logic                    is_query;
    logic                    vec_zero;
    logic [SLOT_W-1:0]       slot;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] ref_count;
    logic [THR_W-1:0] angle_threshold;
  } cfg_t;

  // arctan(2^-i) in Q16 radians
  function automatic logic signed [19:0] atan_step(input logic [3:0] i);
    logic signed [19:0] v;
    unique case (i)
      4'd0:  v = 20'sd51472;
      4'd1:  v = 20'sd30386;
      4'd2:  v = 20'sd16055;
      4'd3:  v = 20'sd8150;
      4'd4:  v = 20'sd4091;
      4'd5:  v = 20'sd2047;
      4'd6:  v = 20'sd1024;
      4'd7:  v = 20'sd512;
      4'd8:  v = 20'sd256;
      4'd9:  v = 20'sd128;
      4'd10: v = 20'sd64;
      4'd11: v = 20'sd32;
      4'd12: v = 20'sd16;
      4'd13: v = 20'sd8;
      4'd14: v = 20'sd4;
      4'd15: v = 20'sd2;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

  // last slot searched: zero searches one, oversize searches all
  function automatic logic [SLOT_W-1:0] count_m1(input logic [CNT_W-1:0] c);
    logic [SLOT_W-1:0] v;
    if (c == '0) begin
      v = '0;
    end else if (c > CNT_W'(MAX_REFS)) begin
      v = SLOT_W'(MAX_REFS - 1);
    end else begin
      v = SLOT_W'(c - CNT_W'(1));
    end
    return v;
  endfunction

endpackage

/* hw/rtl/nearest_direction_gradient.sv */
// ----------------------------------------------------------------------------
// nearest_direction_gradient
// Nearest stored direction by angle, and the geodesic gradient toward it.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): in_mode 0 loads vec into table slot
// in_ref_index and gives no result; in_mode 1 queries with vec and gives one
// result word on the out_ channel (out_valid/out_stall).
// Config port (cfg_valid/cfg_ready, always ready): index 0 ref_count,
// index 1 angle_threshold (Q2.13). Write only while the block is idle.
// Items are handled one at a time by a sequencer behind a two-word queue;
// the input stage keeps taking words while the engine works, until the queue
// and its own register are full. A load is written to the table in the cycle
// it leaves the queue. A query searches N slots, each with 9 multiply steps,
// 3 squares, a square root, a normalize shift loop, 16 CORDIC steps and
// 1 compare (a zero vector goes straight to the compare), plus the gradient
// (products, shift down, square root and three divides) when the angle is not
// below the threshold. The square root unit and the per-slot CORDIC loop take most of the search time.
// Reset empties the queue, clears out_valid, sets ref_count to 1, threshold to 8;
// table contents are undefined until loaded. When out_stall is high the
// result word holds; the engine waits with its next result until taken.
// ----------------------------------------------------------------------------
module nearest_direction_gradient (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_mode,
  input  logic [nrd_pkg::SLOT_W-1:0]           in_ref_index,
  input  logic signed [nrd_pkg::VEC_W-1:0]     in_vec_x,
  input  logic signed [nrd_pkg::VEC_W-1:0]     in_vec_y,
  input  logic signed [nrd_pkg::VEC_W-1:0]     in_vec_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [nrd_pkg::VEC_W-1:0]     out_grad_x,
  output logic signed [nrd_pkg::VEC_W-1:0]     out_grad_y,
  output logic signed [nrd_pkg::VEC_W-1:0]     out_grad_z,
  output logic [nrd_pkg::THR_W-1:0]            out_min_angle,
  output logic [nrd_pkg::SLOT_W-1:0]           out_nearest_slot,
  output logic [1:0]                           out_status,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [nrd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [nrd_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import nrd_pkg::*;

  cfg_t  cfg_r;
  logic  push, q_full, q_valid, q_pop;
  item_t push_item, q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ref_count       <= CNT_W'(1);
      cfg_r.angle_threshold <= THR_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_REF_COUNT: cfg_r.ref_count       <= cfg_data[CNT_W-1:0];
        CFG_ANGLE_THR: cfg_r.angle_threshold <= cfg_data[THR_W-1:0];
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  nrd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_ref_index (in_ref_index),
    .in_vec_x     (in_vec_x),
    .in_vec_y     (in_vec_y),
    .in_vec_z     (in_vec_z),
    .push         (push),
    .push_item    (push_item),
    .q_full       (q_full)
  );

  nrd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (q_pop)
  );

  nrd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_grad_x       (out_grad_x),
    .out_grad_y       (out_grad_y),
    .out_grad_z       (out_grad_z),
    .out_min_angle    (out_min_angle),
    .out_nearest_slot (out_nearest_slot),
    .out_status       (out_status)
  );

  // zero-gradient statuses carry a zero vector
  a_zero_grad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_grad_x == '0 && out_grad_y == '0 && out_grad_z == '0)
    else $error("nonzero gradient with zero status");

  a_below: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BELOW |-> out_min_angle < cfg_r.angle_threshold)
    else $error("below-threshold status with angle at or above threshold");

  a_above: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_min_angle >= cfg_r.angle_threshold)
    else $error("gradient given for angle below threshold");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_angle <= ANGLE_PI &&
      (out_status == ST_OK || out_status == ST_BELOW || out_status == ST_DEGEN))
    else $error("result angle or status out of range");

endmodule

/* hw/rtl/nrd_front.sv */
// ----------------------------------------------------------------------------
// nrd_front
// Input stage: takes words, tags load/query and zero vectors, feeds the queue.
// ----------------------------------------------------------------------------
module nrd_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_mode,
  input  logic [nrd_pkg::SLOT_W-1:0]       in_ref_index,
  input  logic signed [nrd_pkg::VEC_W-1:0] in_vec_x,
  input  logic signed [nrd_pkg::VEC_W-1:0] in_vec_y,
  input  logic signed [nrd_pkg::VEC_W-1:0] in_vec_z,
  output logic                             push,
  output nrd_pkg::item_t                   push_item,
  input  logic                             q_full
);
  import nrd_pkg::*;

  logic  fr_valid_r;
  item_t fr_item_r;
  logic  accept;

  assign in_stall  = fr_valid_r && q_full;
  assign accept    = in_valid && !in_stall;
  assign push      = fr_valid_r && !q_full;
  assign push_item = fr_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (accept) begin
      fr_valid_r <= 1'b1;
    end else if (push) begin
      fr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item_r.is_query <= in_mode;
      fr_item_r.vec_zero <= (in_vec_x == '0) && (in_vec_y == '0) && (in_vec_z == '0);
      fr_item_r.slot     <= in_ref_index;
      fr_item_r.x        <= in_vec_x;
      fr_item_r.y        <= in_vec_y;
      fr_item_r.z        <= in_vec_z;
    end
  end

endmodule

/* hw/rtl/nrd_fifo.sv */
// ----------------------------------------------------------------------------
// nrd_fifo
// Short queue between the input stage and the compute engine.
// ----------------------------------------------------------------------------
module nrd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nrd_pkg::item_t push_item,
  output logic           full,
  output logic           q_valid,
  output nrd_pkg::item_t q_item,
  input  logic           pop
);
  import nrd_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* hw/rtl/nrd_back.sv */
// ----------------------------------------------------------------------------
// nrd_back
// Compute engine: reference table, angle search and gradient sequencer.
// ----------------------------------------------------------------------------
module nrd_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  nrd_pkg::cfg_t                    cfg,
  input  logic                             q_valid,
  input  nrd_pkg::item_t                   q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [nrd_pkg::VEC_W-1:0] out_grad_x,
  output logic signed [nrd_pkg::VEC_W-1:0] out_grad_y,
  output logic signed [nrd_pkg::VEC_W-1:0] out_grad_z,
  output logic [nrd_pkg::THR_W-1:0]        out_min_angle,
  output logic [nrd_pkg::SLOT_W-1:0]       out_nearest_slot,
  output logic [1:0]                       out_status
);
  import nrd_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_MUL  = 12'b0000_0000_0010,
    S_SQ   = 12'b0000_0000_0100,
    S_SQRT = 12'b0000_0000_1000,
    S_NORM = 12'b0000_0001_0000,
    S_CORD = 12'b0000_0010_0000,
    S_CMP  = 12'b0000_0100_0000,
    S_GMUL = 12'b0000_1000_0000,
    S_GSHF = 12'b0001_0000_0000,
    S_GSQ  = 12'b0010_0000_0000,
    S_GDIV = 12'b0100_0000_0000,
    S_OUT  = 12'b1000_0000_0000
  } state_t;

  state_t state_r;

  logic [3*VEC_W-1:0]      tbl_r [MAX_REFS];
  logic signed [VEC_W-1:0] q_r [3];
  logic signed [VEC_W-1:0] r_r [3];
  logic                    qz_r;
  logic signed [32:0]      c_r [3];
  logic signed [33:0]      dot_r;
  logic signed [49:0]      acc_r;
  logic [4:0]              step_r;
  logic                    phase_r;   // 0 search, 1 gradient
  logic [SLOT_W-1:0]       i_r;
  logic [SLOT_W-1:0]       cnt_m1_r;
  logic [THR_W-1:0]        ang_r;
  logic [THR_W-1:0]        best_ang_r;
  logic [SLOT_W-1:0]       best_slot_r;
  logic [31:0]             ux_r;
  logic [31:0]             uy_r;
  logic signed [35:0]      xs_r;
  logic signed [35:0]      ys_r;
  logic signed [19:0]      z_r;
  logic [63:0]             cc_r;
  logic [63:0]             sq_v_r;
  logic [63:0]             sq_r_r;
  logic [63:0]             sq_b_r;
  logic [47:0]             h_r [3];
  logic                    gneg_r [3];
  logic [31:0]             n_r;
  logic [47:0]             rem_r;
  logic [15:0]             quo_r;
  logic [1:0]              k_r;
  logic signed [VEC_W-1:0] g_r [3];
  logic [1:0]              status_r;
  logic                    out_valid_r;
  logic signed [VEC_W-1:0] og_r [3];
  logic [THR_W-1:0]        oang_r;
  logic [SLOT_W-1:0]       oslot_r;
  logic [1:0]              ostat_r;

  // shared signed multiplier for cross, dot and gradient products
  logic [1:0]         sa, sb;
  logic signed [33:0] ma;
  logic signed [16:0] mb;
  logic signed [50:0] prod, acc_sum, acc_dif;
  logic [47:0]        dif_abs;

  always_comb begin
    unique case (step_r[3:0])
      4'd0:    begin sa = 2'd1; sb = 2'd2; end
      4'd1:    begin sa = 2'd2; sb = 2'd1; end
      4'd2:    begin sa = 2'd2; sb = 2'd0; end
      4'd3:    begin sa = 2'd0; sb = 2'd2; end
      4'd4:    begin sa = 2'd0; sb = 2'd1; end
      4'd5:    begin sa = 2'd1; sb = 2'd0; end
      4'd7:    begin sa = 2'd1; sb = 2'd1; end
      4'd8:    begin sa = 2'd2; sb = 2'd2; end
      default: begin sa = 2'd0; sb = 2'd0; end
    endcase
  end

  assign ma      = (state_r == S_GMUL) ? 34'(c_r[sa]) : 34'(q_r[sa]);
  assign mb      = (state_r == S_GMUL) ? 17'(q_r[sb]) : 17'(r_r[sb]);
  assign prod    = ma * mb;
  assign acc_sum = 51'(acc_r) + prod;
  assign acc_dif = 51'(acc_r) - prod;
  assign dif_abs = acc_dif[50] ? 48'(-acc_dif) : 48'(acc_dif);

  // shared unsigned multiplier for squares and the divide dividend
  logic [31:0] ua, ub;
  logic [63:0] uprod;
  logic [31:0] cabs;

  assign cabs = c_r[step_r[1:0]][32] ? 32'(-c_r[step_r[1:0]]) : 32'(c_r[step_r[1:0]]);

  always_comb begin
    ua = '0;
    ub = '0;
    if (state_r == S_SQ) begin
      ua = cabs;
      ub = cabs;
    end else if (state_r == S_GSQ) begin
      ua = h_r[step_r[1:0]][31:0];
      ub = h_r[step_r[1:0]][31:0];
    end else if (state_r == S_GDIV) begin
      ua = h_r[k_r][31:0];
      ub = 32'(best_ang_r);
    end
  end

  assign uprod = ua * ub;

  // square root, two bits per cycle
  logic [64:0] sq_trial;
  logic        sq_ge;
  logic [63:0] sq_r_nxt;
  logic [31:0] root;

  assign sq_trial = {1'b0, sq_r_r} + {1'b0, sq_b_r};
  assign sq_ge    = ({1'b0, sq_v_r} >= sq_trial);
  assign sq_r_nxt = sq_ge ? ((sq_r_r >> 1) + sq_b_r) : (sq_r_r >> 1);
  assign root     = sq_r_nxt[31:0];

  // cordic vectoring step
  logic signed [35:0] dx, dy;
  logic signed [19:0] z_new;
  logic [31:0]        uo;

  assign dx    = ys_r >>> step_r[3:0];
  assign dy    = xs_r >>> step_r[3:0];
  assign z_new = ys_r[35] ? (z_r - atan_step(step_r[3:0])) : (z_r + atan_step(step_r[3:0]));
  assign uo    = ux_r | uy_r;

  function automatic logic [THR_W-1:0] z_to_angle(input logic signed [19:0] z);
    logic signed [19:0] t;
    logic [THR_W-1:0]   a;
    t = (z + 20'sd4) >>> 3;
    if (z < 0) begin
      a = '0;
    end else if (t > 20'sd25736) begin
      a = ANGLE_PI;
    end else begin
      a = t[THR_W-1:0];
    end
    return a;
  endfunction

  // search bookkeeping and table read
  logic              rz, upd, last;
  logic [THR_W-1:0]  fin_ang;
  logic [SLOT_W-1:0] fin_slot, rd_idx;
  logic [3*VEC_W-1:0] rsel;

  assign rz       = (r_r[0] == '0) && (r_r[1] == '0) && (r_r[2] == '0);
  assign upd      = (i_r == '0) || (ang_r < best_ang_r);
  assign fin_ang  = upd ? ang_r : best_ang_r;
  assign fin_slot = upd ? i_r : best_slot_r;
  assign last     = (i_r == cnt_m1_r);
  assign rd_idx   = (state_r == S_CMP) ? (last ? fin_slot : i_r + SLOT_W'(1)) : '0;
  assign rsel     = tbl_r[rd_idx];

  // restoring divide, one quotient bit per cycle
  logic [3:0]  dj;
  logic [47:0] dsh;
  logic        dge;
  logic [15:0] quo_new;

  assign dj      = 4'(5'd16 - step_r);
  assign dsh     = 48'(n_r) << dj;
  assign dge     = (rem_r >= dsh);
  assign quo_new = quo_r | (dge ? (16'd1 << dj) : 16'd0);

  assign q_pop = (state_r == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_OUT) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.is_query) begin
              q_r[0]   <= q_item.x;
              q_r[1]   <= q_item.y;
              q_r[2]   <= q_item.z;
              qz_r     <= q_item.vec_zero;
              i_r      <= '0;
              cnt_m1_r <= count_m1(cfg.ref_count);
              r_r[0]   <= rsel[15:0];
              r_r[1]   <= rsel[31:16];
              r_r[2]   <= rsel[47:32];
              phase_r  <= 1'b0;
              step_r   <= '0;
              state_r  <= S_MUL;
            end else begin
              tbl_r[q_item.slot] <= {q_item.z, q_item.y, q_item.x};
            end
          end
        end
        S_MUL: begin
          unique case (step_r[3:0])
            4'd0, 4'd2, 4'd4, 4'd6: acc_r <= 50'(prod);
            4'd1: c_r[0] <= 33'(acc_dif);
            4'd3: c_r[1] <= 33'(acc_dif);
            4'd5: c_r[2] <= 33'(acc_dif);
            4'd7: acc_r <= 50'(acc_sum);
            4'd8: dot_r <= 34'(acc_sum);
            default: acc_r <= acc_r;
          endcase
          if (phase_r && step_r == 5'd5) begin
            step_r  <= '0;
            state_r <= S_GMUL;
          end else if (!phase_r && step_r == 5'd8) begin
            step_r <= '0;
            cc_r   <= '0;
            if (qz_r || rz) begin
              ang_r   <= ANGLE_HALF_PI;
              state_r <= S_CMP;
            end else begin
              state_r <= S_SQ;
            end
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        S_SQ, S_GSQ: begin
          cc_r <= cc_r + uprod;
          if (step_r == 5'd2) begin
            sq_v_r  <= cc_r + uprod;
            sq_r_r  <= '0;
            sq_b_r  <= 64'h4000_0000_0000_0000;
            step_r  <= '0;
            state_r <= S_SQRT;
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_v_r <= sq_v_r - sq_trial[63:0];
          end
          sq_r_r <= sq_r_nxt;
          sq_b_r <= sq_b_r >> 2;
          if (step_r == 5'd31) begin
            step_r <= '0;
            if (!phase_r) begin
              if (dot_r[33]) begin
                ux_r <= root;
                uy_r <= 32'(-dot_r);
                z_r  <= HALF_PI_Q16;
              end else begin
                ux_r <= dot_r[31:0];
                uy_r <= root;
                z_r  <= '0;
              end
              state_r <= S_NORM;
            end else begin
              n_r <= root;
              if (root == '0) begin
                status_r <= ST_DEGEN;
                g_r[0]   <= '0;
                g_r[1]   <= '0;
                g_r[2]   <= '0;
                state_r  <= S_OUT;
              end else begin
                k_r     <= '0;
                state_r <= S_GDIV;
              end
            end
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        S_NORM: begin
          priority if (uo == '0) begin
            ang_r   <= '0;
            state_r <= S_CMP;
          end else if (uo[31]) begin
            xs_r    <= $signed({4'b0, ux_r});
            ys_r    <= $signed({4'b0, uy_r});
            step_r  <= '0;
            state_r <= S_CORD;
          end else if (uo[31:16] == '0) begin
            ux_r <= ux_r << 16;
            uy_r <= uy_r << 16;
          end else if (uo[31:28] == '0) begin
            ux_r <= ux_r << 4;
            uy_r <= uy_r << 4;
          end else begin
            ux_r <= ux_r << 1;
            uy_r <= uy_r << 1;
          end
        end
        S_CORD: begin
          if (!ys_r[35]) begin
            xs_r <= xs_r + dx;
            ys_r <= ys_r - dy;
          end else begin
            xs_r <= xs_r - dx;
            ys_r <= ys_r + dy;
          end
          z_r <= z_new;
          if (step_r == 5'd15) begin
            ang_r   <= z_to_angle(z_new);
            step_r  <= '0;
            state_r <= S_CMP;
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        S_CMP: begin
          best_ang_r  <= fin_ang;
          best_slot_r <= fin_slot;
          r_r[0]      <= rsel[15:0];
          r_r[1]      <= rsel[31:16];
          r_r[2]      <= rsel[47:32];
          step_r      <= '0;
          if (!last) begin
            i_r     <= i_r + SLOT_W'(1);
            state_r <= S_MUL;
          end else if (fin_ang < cfg.angle_threshold) begin
            status_r <= ST_BELOW;
            g_r[0]   <= '0;
            g_r[1]   <= '0;
            g_r[2]   <= '0;
            state_r  <= S_OUT;
          end else begin
            phase_r <= 1'b1;
            state_r <= S_MUL;
          end
        end
        S_GMUL: begin
          unique case (step_r[3:0])
            4'd1:    begin h_r[0] <= dif_abs; gneg_r[0] <= acc_dif[50]; end
            4'd3:    begin h_r[1] <= dif_abs; gneg_r[1] <= acc_dif[50]; end
            4'd5:    begin h_r[2] <= dif_abs; gneg_r[2] <= acc_dif[50]; end
            default: acc_r <= 50'(prod);
          endcase
          if (step_r == 5'd5) begin
            step_r  <= '0;
            state_r <= S_GSHF;
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        S_GSHF: begin
          // bring every component below 2^30
          if ((h_r[0][47:30] | h_r[1][47:30] | h_r[2][47:30]) != '0) begin
            h_r[0] <= h_r[0] >> 1;
            h_r[1] <= h_r[1] >> 1;
            h_r[2] <= h_r[2] >> 1;
          end else begin
            cc_r    <= '0;
            step_r  <= '0;
            state_r <= S_GSQ;
          end
        end
        S_GDIV: begin
          if (step_r == '0) begin
            rem_r  <= 48'(uprod) + 48'(n_r >> 1);
            quo_r  <= '0;
            step_r <= 5'd1;
          end else begin
            if (dge) begin
              rem_r <= rem_r - dsh;
            end
            quo_r <= quo_new;
            if (step_r == 5'd16) begin
              g_r[k_r] <= gneg_r[k_r] ? -$signed(quo_new) : $signed(quo_new);
              step_r   <= '0;
              if (k_r == 2'd2) begin
                status_r <= ST_OK;
                state_r  <= S_OUT;
              end else begin
                k_r <= k_r + 2'd1;
              end
            end else begin
              step_r <= step_r + 5'd1;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            og_r[0] <= g_r[0];
            og_r[1] <= g_r[1];
            og_r[2] <= g_r[2];
            oang_r  <= best_ang_r;
            oslot_r <= best_slot_r;
            ostat_r <= status_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_grad_x       = og_r[0];
  assign out_grad_y       = og_r[1];
  assign out_grad_z       = og_r[2];
  assign out_min_angle    = oang_r;
  assign out_nearest_slot = oslot_r;
  assign out_status       = ostat_r;

endmodule
